>>> hdl/bir_pkg.sv
// Shared types and constants for the bilinear tile resampler.
// Used by bilinear_image_resampler; no dependencies.
package bir_pkg;

    // default sizing, handed to the top-level parameters
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_OUT_DIM  = 4096;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int ST_ADDR_W = 18;   // tile store address width
    localparam int MUL_B_W   = 17;   // narrow operand of the shared multiplier

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_CHANS = 3'd4;
    localparam logic [2:0] REG_FMT   = 3'd5;

    // sample formats
    localparam logic [1:0] FMT_8  = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;

    // register reset values
    localparam logic [8:0]  RST_SRC_W = 9'd256;
    localparam logic [8:0]  RST_SRC_H = 9'd256;
    localparam logic [12:0] RST_DST_W = 13'd256;
    localparam logic [12:0] RST_DST_H = 13'd256;
    localparam logic [2:0]  RST_CHANS = 3'd3;
    localparam logic [1:0]  RST_FMT   = FMT_8;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample;
        logic [17:0] sample_index;
        logic [11:0] out_x;
        logic [11:0] out_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  channel;
        logic        last;
    } t_out_item;

endpackage

>>> hdl/bilinear_image_resampler.sv
// Bilinear tile resampler: tile store, scale-step divider, shared-multiplier sequencer.
// Depends on bir_pkg and bir_div.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------------------
//  command   | start, busy, i_item                       | taken when start & !busy
//  result    | o_strobe, o_result                        | one cycle per strobe, no stall
//  config    | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// A load transaction is written to the tile store as it is accepted. For a pixel
// request each channel costs four tile reads, four address multiplies and eight
// passes through the single 32x17 multiply-accumulate unit, with busy high until
// the last result. After reset and after each write to one of the six registers
// the divider runs twice, with busy high, to rebuild the x and y steps. Results
// cannot be stalled; strobe marks each one.
module bilinear_image_resampler #(
    parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_OUT_DIM  = bir_pkg::DEF_MAX_OUT_DIM,
    parameter int FRAC_BITS    = bir_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bir_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output bir_pkg::t_out_item  o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bir_pkg::*;

    localparam int W_DEN = $clog2(MAX_OUT_DIM + 1);
    localparam int W_H   = 32 + FRAC_BITS;
    localparam logic [MUL_B_W-1:0] ONE = MUL_B_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_CFGX, S_DIVX, S_CFGY, S_DIVY, S_IDLE,
        S_PX, S_PY, S_ROW0, S_ROW1, S_ROW2, S_ROW3,
        S_ADR, S_RD, S_MAC, S_FIN
    } t_state;

    t_state r_state;

    logic [8:0]  r_src_w, r_src_h;
    logic [12:0] r_dst_w, r_dst_h;
    logic [2:0]  r_chan_cnt;
    logic [1:0]  r_fmt;
    logic [31:0] r_x_step, r_y_step;
    logic [11:0] r_out_x, r_out_y;
    logic [48:0] r_prod;
    logic [12:0] r_x0, r_x1, r_y0, r_y1;
    logic [MUL_B_W-1:0] r_fx, r_fy;
    logic [ST_ADDR_W-1:0] r_row0, r_row1;
    logic [1:0]  r_nb, r_ch, r_ph;
    logic [63:0] r_acc;
    logic [W_H-1:0] r_h0, r_h1;
    logic [31:0] r_rdata;
    logic        r_strobe;
    t_out_item   r_result;

    logic [31:0] tile_mem [2**ST_ADDR_W];

    logic [12:0]      w_sw, w_sh;
    logic [W_DEN-1:0] w_dw, w_dh;
    logic [2:0]       w_chans;
    logic [31:0]      w_mask;
    logic             w_cfg_wr, w_accept;
    logic             w_div_start, w_div_done, w_div_y;
    logic [31:0]      w_div_num, w_div_quo;
    logic [W_DEN-1:0] w_div_den;
    logic [48:0]      w_pint;
    logic [12:0]      w_lim, w_c0, w_c1;
    logic             w_clamp;
    logic [MUL_B_W-1:0] w_cf;
    logic [31:0]      w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [48:0]      w_prod;
    logic             w_clr, w_shift;
    logic [63:0]      n_acc;
    logic [W_H-1:0]   w_h;
    logic [ST_ADDR_W-1:0] w_pix, w_rd_addr;
    logic             w_last;

    // register clamps
    always_comb begin
        if (r_src_w == '0)                w_sw = 13'd1;
        else if (32'(r_src_w) > MAX_WIDTH) w_sw = 13'(MAX_WIDTH);
        else                              w_sw = 13'(r_src_w);
        if (r_src_h == '0)                 w_sh = 13'd1;
        else if (32'(r_src_h) > MAX_HEIGHT) w_sh = 13'(MAX_HEIGHT);
        else                               w_sh = 13'(r_src_h);
        if (r_dst_w == '0)                   w_dw = W_DEN'(1);
        else if (32'(r_dst_w) > MAX_OUT_DIM) w_dw = W_DEN'(MAX_OUT_DIM);
        else                                 w_dw = W_DEN'(r_dst_w);
        if (r_dst_h == '0)                   w_dh = W_DEN'(1);
        else if (32'(r_dst_h) > MAX_OUT_DIM) w_dh = W_DEN'(MAX_OUT_DIM);
        else                                 w_dh = W_DEN'(r_dst_h);
        if (r_chan_cnt == '0)                    w_chans = 3'd1;
        else if (32'(r_chan_cnt) > MAX_CHANNELS) w_chans = 3'(MAX_CHANNELS);
        else                                     w_chans = r_chan_cnt;
        case (r_fmt)
            FMT_8:   w_mask = 32'h0000_00FF;
            FMT_16:  w_mask = 32'h0000_FFFF;
            default: w_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    // step = (src << FRAC_BITS) / dst
    assign w_div_start = (r_state == S_CFGX) || (r_state == S_CFGY);
    assign w_div_y     = (r_state == S_CFGY) || (r_state == S_DIVY);
    assign w_div_num   = w_div_y ? (32'(w_sh) << FRAC_BITS) : (32'(w_sw) << FRAC_BITS);
    assign w_div_den   = w_div_y ? w_dh : w_dw;

    bir_div #(
        .W_DEN (W_DEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // split a position product into integer and fraction, clamp at the edge
    assign w_pint  = r_prod >> FRAC_BITS;
    assign w_lim   = (r_state == S_ROW0) ? (w_sh - 13'd1) : (w_sw - 13'd1);
    assign w_clamp = w_pint >= 49'(w_lim);
    assign w_c0    = w_clamp ? w_lim : w_pint[12:0];
    assign w_c1    = w_clamp ? w_lim : (w_pint[12:0] + 13'd1);
    assign w_cf    = w_clamp ? '0 : MUL_B_W'(r_prod[FRAC_BITS-1:0]);

    assign w_pix     = (r_nb[1] ? r_row1 : r_row0) + ST_ADDR_W'(r_nb[0] ? r_x1 : r_x0);
    assign w_rd_addr = r_prod[ST_ADDR_W-1:0] + ST_ADDR_W'(r_ch);
    assign w_h       = r_ph[1] ? r_h1 : r_h0;
    assign w_last    = ({1'b0, r_ch} == (w_chans - 3'd1));

    // operand selection for the shared multiplier
    always_comb begin
        case (r_state)
            S_PX: begin
                w_mul_a = r_x_step;
                w_mul_b = MUL_B_W'(r_out_x);
            end
            S_PY: begin
                w_mul_a = r_y_step;
                w_mul_b = MUL_B_W'(r_out_y);
            end
            S_ROW1: begin
                w_mul_a = 32'(r_y0);
                w_mul_b = MUL_B_W'(w_sw);
            end
            S_ROW2: begin
                w_mul_a = 32'(r_y1);
                w_mul_b = MUL_B_W'(w_sw);
            end
            S_ADR: begin
                w_mul_a = 32'(w_pix);
                w_mul_b = MUL_B_W'(w_chans);
            end
            S_MAC: begin
                w_mul_a = r_rdata & w_mask;
                w_mul_b = r_nb[0] ? r_fx : (ONE - r_fx);
            end
            S_FIN: begin
                w_mul_a = r_ph[0] ? 32'(w_h[W_H-1:32]) : w_h[31:0];
                w_mul_b = r_ph[1] ? r_fy : (ONE - r_fy);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = 49'(w_mul_a) * 49'(w_mul_b);
    assign w_clr   = (r_state == S_MAC) ? ~r_nb[0] : (r_ph == 2'd0);
    assign w_shift = (r_state == S_FIN) && r_ph[0];
    assign n_acc   = (w_clr ? 64'd0 : r_acc)
                   + (w_shift ? {w_prod[31:0], 32'd0} : 64'(w_prod));

    // tile store, single port
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.kind == KIND_LOAD) begin
            tile_mem[i_item.sample_index] <= i_item.sample;
        end else if (r_state == S_RD) begin
            r_rdata <= tile_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CFGX;
            r_src_w    <= RST_SRC_W;
            r_src_h    <= RST_SRC_H;
            r_dst_w    <= RST_DST_W;
            r_dst_h    <= RST_DST_H;
            r_chan_cnt <= RST_CHANS;
            r_fmt      <= RST_FMT;
            r_x_step   <= '0;
            r_y_step   <= '0;
            r_nb       <= '0;
            r_ch       <= '0;
            r_ph       <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CFGX: r_state <= S_DIVX;
                S_DIVX: begin
                    if (w_div_done) begin
                        r_x_step <= w_div_quo;
                        r_state  <= S_CFGY;
                    end
                end
                S_CFGY: r_state <= S_DIVY;
                S_DIVY: begin
                    if (w_div_done) begin
                        r_y_step <= w_div_quo;
                        r_state  <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && i_item.kind == KIND_REQ) begin
                        r_out_x <= i_item.out_x;
                        r_out_y <= i_item.out_y;
                        r_state <= S_PX;
                    end
                end
                S_PX: begin
                    r_prod  <= w_prod;
                    r_state <= S_PY;
                end
                S_PY: begin
                    r_prod  <= w_prod;
                    r_x0    <= w_c0;
                    r_x1    <= w_c1;
                    r_fx    <= w_cf;
                    r_state <= S_ROW0;
                end
                S_ROW0: begin
                    r_y0    <= w_c0;
                    r_y1    <= w_c1;
                    r_fy    <= w_cf;
                    r_state <= S_ROW1;
                end
                S_ROW1: begin
                    r_prod  <= w_prod;
                    r_state <= S_ROW2;
                end
                S_ROW2: begin
                    r_row0  <= r_prod[ST_ADDR_W-1:0];
                    r_prod  <= w_prod;
                    r_state <= S_ROW3;
                end
                S_ROW3: begin
                    r_row1  <= r_prod[ST_ADDR_W-1:0];
                    r_nb    <= '0;
                    r_ch    <= '0;
                    r_state <= S_ADR;
                end
                S_ADR: begin
                    r_prod  <= w_prod;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_MAC;
                S_MAC: begin
                    // top pair then bottom pair, each blended along x
                    r_acc <= n_acc;
                    if (r_nb == 2'd1) r_h0 <= n_acc[W_H-1:0];
                    if (r_nb == 2'd3) begin
                        r_h1    <= n_acc[W_H-1:0];
                        r_ph    <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_nb    <= r_nb + 2'd1;
                        r_state <= S_ADR;
                    end
                end
                S_FIN: begin
                    r_acc <= n_acc;
                    r_ph  <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        r_strobe         <= 1'b1;
                        r_result.value   <= n_acc[2*FRAC_BITS +: 32] & w_mask;
                        r_result.channel <= r_ch;
                        r_result.last    <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_nb    <= '0;
                            r_state <= S_ADR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_SRC_W: r_src_w    <= pwdata[8:0];
                    REG_SRC_H: r_src_h    <= pwdata[8:0];
                    REG_DST_W: r_dst_w    <= pwdata[12:0];
                    REG_DST_H: r_dst_h    <= pwdata[12:0];
                    REG_CHANS: r_chan_cnt <= pwdata[2:0];
                    REG_FMT:   r_fmt      <= pwdata[1:0];
                    default: ;
                endcase
                if (paddr[4:2] <= REG_FMT) r_state <= S_CFGX;
            end
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SRC_W: prdata = 32'(r_src_w);
            REG_SRC_H: prdata = 32'(r_src_h);
            REG_DST_W: prdata = 32'(r_dst_w);
            REG_DST_H: prdata = 32'(r_dst_h);
            REG_CHANS: prdata = 32'(r_chan_cnt);
            REG_FMT:   prdata = 32'(r_fmt);
            default:   prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last) |-> (r_state == S_IDLE || r_state == S_CFGX))
        else $error("last result issued while request still active");

    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == KIND_REQ) |=> (r_state == S_PX || r_state == S_CFGX))
        else $error("accepted request did not start the sequencer");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ({1'b0, r_ch} < w_chans))
        else $error("channel counter beyond channel count");

    a_value_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ((r_result.value & ~$past(w_mask)) == 32'd0))
        else $error("result wider than sample format");

    a_edge_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADR && r_x0 == r_x1) |-> (r_fx == '0))
        else $error("nonzero x fraction at clamped column");
`endif

endmodule

>>> hdl/bir_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit dividend.
// Computes the fixed-point scale steps; depends on nothing else.
module bir_div #(
    parameter int W_DEN = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_num,
    input  logic [W_DEN-1:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);
    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [W_DEN-1:0] r_rem;
    logic [31:0]      r_quo;

    logic [W_DEN:0] w_trial;
    logic [W_DEN:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = w_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits W_DEN bits
                r_rem <= w_ge ? w_diff[W_DEN-1:0] : w_trial[W_DEN-1:0];
                r_quo <= {r_quo[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
